[hw/rtl/zsce_pkg.sv]
// ----------------------------------------------------------------------------
// zsce_pkg
// Shared types, constants and helpers of the zoomed sprite chunk expander.
// ----------------------------------------------------------------------------
package zsce_pkg;

    localparam int MapAddrBitsDef = 17;
    localparam int TileBits       = 15;
    localparam int BaseBits       = TileBits + 2;

    localparam int CmdDepth = 2;
    localparam int CmdPtrW  = 1;
    localparam int CmdCntW  = 2;

    localparam int OutDepth = 4;
    localparam int OutPtrW  = 2;
    localparam int OutCntW  = 3;

    localparam logic [2:0] CfgXOffset   = 3'd0;
    localparam logic [2:0] CfgYOffset   = 3'd1;
    localparam logic [2:0] CfgPrimask0  = 3'd2;
    localparam logic [2:0] CfgPrimask1  = 3'd3;
    localparam logic [2:0] CfgPrimask2  = 3'd4;
    localparam logic [2:0] CfgPrimask3  = 3'd5;

    localparam logic [10:0] XOffsetReset  = 11'h02c;
    localparam logic [10:0] YOffsetReset  = 11'h5c2;
    localparam logic [15:0] Primask0Reset = 16'hfffc;
    localparam logic [15:0] Primask1Reset = 16'hfff0;
    localparam logic [15:0] Primask2Reset = 16'hff00;
    localparam logic [15:0] Primask3Reset = 16'h0000;

    localparam logic [9:0]  WrapLimit  = 10'h340;
    localparam logic [12:0] WrapAmount = 13'h400;
    localparam logic [15:0] EmptyCode  = 16'hffff;
    localparam logic [7:0]  PalBase    = 8'h80;

    typedef struct packed {
        logic               is_write;
        logic [15:0]        wdata;
        logic               flip_x;
        logic               flip_y;
        logic               dbl;
        logic [7:0]         zoom_x;
        logic [7:0]         zoom_y;
        logic [7:0]         palette;
        logic [15:0]        prio_mask;
        logic [12:0]        pos_x;
        logic [12:0]        pos_y;
    } t_cmd;

    typedef struct packed {
        logic [15:0]        tile_code;
        logic [7:0]         palette;
        logic               mirror_x;
        logic               mirror_y;
        logic signed [12:0] pos_x;
        logic signed [12:0] pos_y;
        logic [18:0]        scale_x;
        logic [18:0]        scale_y;
        logic [15:0]        prio_mask;
        logic               last;
    } t_result;

    // k * z for k up to 4, z up to 128
    function automatic logic [10:0] zoom_mul(input logic [2:0] k, input logic [7:0] z);
        logic [10:0] zz;
        zz = {3'b000, z};
        return (k[0] ? zz : 11'd0) + (k[1] ? (zz << 1) : 11'd0) + (k[2] ? (zz << 2) : 11'd0);
    endfunction

endpackage

[hw/rtl/zsce_front.sv]
// ----------------------------------------------------------------------------
// zsce_front
// Accepts words, holds the alignment registers, decodes sprite entries and
// queues map writes and sprite commands for the back end.
// ----------------------------------------------------------------------------
module zsce_front #(
    parameter int MAP_ADDR_BITS = zsce_pkg::MapAddrBitsDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic                     i_func,
    input  logic [MAP_ADDR_BITS-1:0] i_map_address,
    input  logic [15:0]              i_map_word,
    input  logic [31:0]              i_attr_word_a,
    input  logic [31:0]              i_attr_word_c,
    input  logic [31:0]              i_attr_word_d,
    input  logic                     i_cfg_wr_en,
    input  logic [2:0]               i_cfg_addr,
    input  logic [15:0]              i_cfg_wdata,
    output logic                     o_cmd_valid,
    output zsce_pkg::t_cmd           o_cmd,
    output logic [MAP_ADDR_BITS-1:0] o_cmd_addr,
    input  logic                     i_cmd_pop
);
    import zsce_pkg::*;

    logic [10:0] r_x_off;
    logic [10:0] r_y_off;
    logic [15:0] r_primask [4];

    t_cmd                     r_q_cmd  [CmdDepth];
    logic [MAP_ADDR_BITS-1:0] r_q_addr [CmdDepth];
    logic [CmdPtrW-1:0]       r_wr_ptr;
    logic [CmdPtrW-1:0]       r_rd_ptr;
    logic [CmdCntW-1:0]       r_count;

    t_cmd                     dec;
    logic [MAP_ADDR_BITS-1:0] dec_addr;
    logic [TileBits-1:0]      tile;
    logic [BaseBits-1:0]      base_full;
    logic [1:0]               prio;
    logic [9:0]               ux;
    logic [9:0]               uy;
    logic [12:0]              x_wrap;
    logic [12:0]              y_sum;
    logic                     accept;
    logic                     q_push;
    logic                     q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_off     <= XOffsetReset;
            r_y_off     <= YOffsetReset;
            r_primask[0] <= Primask0Reset;
            r_primask[1] <= Primask1Reset;
            r_primask[2] <= Primask2Reset;
            r_primask[3] <= Primask3Reset;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CfgXOffset:  r_x_off      <= i_cfg_wdata[10:0];
                CfgYOffset:  r_y_off      <= i_cfg_wdata[10:0];
                CfgPrimask0: r_primask[0] <= i_cfg_wdata;
                CfgPrimask1: r_primask[1] <= i_cfg_wdata;
                CfgPrimask2: r_primask[2] <= i_cfg_wdata;
                CfgPrimask3: r_primask[3] <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        tile      = i_attr_word_a[TileBits-1:0];
        base_full = {tile, 2'b00};
        prio      = i_attr_word_c[19:18];
        ux        = i_attr_word_c[9:0];
        uy        = 10'h000 - i_attr_word_d[9:0];

        x_wrap = {3'b000, ux} - ((ux > WrapLimit) ? WrapAmount : 13'h000);
        y_sum  = {3'b000, uy} + {{2{r_y_off[10]}}, r_y_off};

        dec           = '0;
        dec.is_write  = !i_func;
        dec.wdata     = i_map_word;
        dec.flip_x    = i_attr_word_a[23];
        dec.flip_y    = i_attr_word_d[17];
        dec.dbl       = i_attr_word_d[18];
        dec.zoom_x    = {1'b0, i_attr_word_a[22:16]} + 8'd1;
        dec.zoom_y    = {1'b0, i_attr_word_d[16:10]} + 8'd1;
        dec.palette   = PalBase | {1'b0, i_attr_word_c[17:11]} | {1'b0, prio, 5'b00000};
        dec.prio_mask = r_primask[prio];
        dec.pos_x     = x_wrap - {{2{r_x_off[10]}}, r_x_off};
        dec.pos_y     = ($signed(y_sum) > $signed({3'b000, WrapLimit})) ?
                        (y_sum - WrapAmount) : y_sum;

        dec_addr = i_func ? base_full[MAP_ADDR_BITS-1:0] : i_map_address;
    end

    assign o_full = (r_count == CmdCntW'(CmdDepth));
    assign accept = i_push && !o_full;
    // sprites with a zero tile give nothing and are dropped here
    assign q_push = accept && (!i_func || (tile != '0));
    assign q_pop  = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (q_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (q_push && !q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (q_pop && !q_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q_cmd[r_wr_ptr]  <= dec;
            r_q_addr[r_wr_ptr] <= dec_addr;
        end
    end

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q_cmd[r_rd_ptr];
    assign o_cmd_addr  = r_q_addr[r_rd_ptr];

endmodule

[hw/rtl/zsce_back.sv]
// ----------------------------------------------------------------------------
// zsce_back
// Holds the chunk map, does map writes and walks each sprite's chunk grid, one
// map read per cycle unless stalled, holding a kept chunk to mark the last.
// ----------------------------------------------------------------------------
module zsce_back #(
    parameter int MAP_ADDR_BITS = zsce_pkg::MapAddrBitsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  zsce_pkg::t_cmd               i_cmd,
    input  logic [MAP_ADDR_BITS-1:0]     i_cmd_addr,
    output logic                         o_cmd_pop,
    input  logic [zsce_pkg::OutCntW-1:0] i_out_count,
    output logic                         o_push,
    output zsce_pkg::t_result            o_word
);
    import zsce_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_RUN    = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    logic [15:0] mem [2**MAP_ADDR_BITS];

    t_state                   r_state;
    t_state                   n_state;
    t_cmd                     r_cmd;
    logic [MAP_ADDR_BITS-1:0] r_base;
    logic [3:0]               r_n;
    logic                     r_stg_valid;
    logic [1:0]               r_stg_col;
    logic [1:0]               r_stg_row;
    logic [15:0]              r_rd_data;
    t_result                  r_pend;
    logic                     r_pend_valid;

    logic [1:0]               col;
    logic [1:0]               row;
    logic [1:0]               flip_mask;
    logic [1:0]               px;
    logic [1:0]               py;
    logic [3:0]               offset;
    logic [MAP_ADDR_BITS-1:0] rd_addr;
    logic                     issue;
    logic                     issue_last;
    logic                     mem_we;
    logic                     kept;
    logic                     fin_go;
    logic [10:0]              px0;
    logic [10:0]              px1;
    logic [10:0]              py0;
    logic [10:0]              py1;
    logic [7:0]               ox0;
    logic [7:0]               ox1;
    logic [7:0]               oy0;
    logic [7:0]               oy1;
    logic [7:0]               size_x;
    logic [7:0]               size_y;
    logic [12:0]              cx;
    logic [12:0]              cy;
    t_result                  new_res;

    always_comb begin
        col        = r_cmd.dbl ? r_n[1:0] : {1'b0, r_n[0]};
        row        = r_cmd.dbl ? r_n[3:2] : {1'b0, r_n[1]};
        flip_mask  = r_cmd.dbl ? 2'b11 : 2'b01;
        px         = r_cmd.flip_x ? (col ^ flip_mask) : col;
        py         = r_cmd.flip_y ? (row ^ flip_mask) : row;
        offset     = r_cmd.dbl ? {py, px} : {2'b00, py[0], px[0]};
        rd_addr    = r_base + MAP_ADDR_BITS'(offset);
        issue_last = (r_n == (r_cmd.dbl ? 4'hf : 4'h3));
        issue      = (r_state == S_RUN) &&
                     (({1'b0, i_out_count} + {3'b000, r_stg_valid}) < 4'(OutDepth));
        mem_we     = (r_state == S_IDLE) && i_cmd_valid && i_cmd.is_write;
        o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    end

    always_comb begin
        px0 = zoom_mul({1'b0, r_stg_col}, r_cmd.zoom_x);
        px1 = zoom_mul({1'b0, r_stg_col} + 3'd1, r_cmd.zoom_x);
        py0 = zoom_mul({1'b0, r_stg_row}, r_cmd.zoom_y);
        py1 = zoom_mul({1'b0, r_stg_row} + 3'd1, r_cmd.zoom_y);
        ox0 = r_cmd.dbl ? px0[9:2] : px0[8:1];
        ox1 = r_cmd.dbl ? px1[9:2] : px1[8:1];
        oy0 = r_cmd.dbl ? py0[9:2] : py0[8:1];
        oy1 = r_cmd.dbl ? py1[9:2] : py1[8:1];
        size_x = ox1 - ox0;
        size_y = oy1 - oy0;
        cx = r_cmd.pos_x + {5'b00000, ox0};
        cy = r_cmd.pos_y + {5'b00000, oy0};

        new_res           = '0;
        new_res.tile_code = r_rd_data;
        new_res.palette   = r_cmd.palette;
        new_res.mirror_x  = !r_cmd.flip_x;
        new_res.mirror_y  = r_cmd.flip_y;
        new_res.pos_x     = $signed(cx);
        new_res.pos_y     = $signed(cy);
        new_res.scale_x   = {size_x[6:0], 12'h000};
        new_res.scale_y   = {size_y[6:0], 12'h000};
        new_res.prio_mask = r_cmd.prio_mask;
        new_res.last      = 1'b0;
    end

    assign kept   = r_stg_valid && (r_rd_data != EmptyCode);
    assign fin_go = (r_state == S_FINISH) && !r_stg_valid &&
                    (i_out_count < OutCntW'(OutDepth));

    always_comb begin
        o_push      = (kept && r_pend_valid) || (fin_go && r_pend_valid);
        o_word      = r_pend;
        o_word.last = fin_go;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !i_cmd.is_write) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (issue && issue_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_stg_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stg_valid <= issue;
            if (kept) begin
                r_pend_valid <= 1'b1;
            end else if (fin_go) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && !i_cmd.is_write) begin
            r_cmd  <= i_cmd;
            r_base <= i_cmd_addr;
            r_n    <= 4'h0;
        end else if (issue) begin
            r_n <= r_n + 4'h1;
        end
        if (issue) begin
            r_stg_col <= col;
            r_stg_row <= row;
        end
        if (kept) begin
            r_pend <= new_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_cmd_addr] <= i_cmd.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_out_count < OutCntW'(OutDepth)))
        else $error("result pushed into a full queue");

    a_stage_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_valid |-> $past(r_state == S_RUN))
        else $error("map read outside a sprite walk");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_pend_valid && !r_stg_valid))
        else $error("chunk left behind at end of sprite");

endmodule

[hw/rtl/zsce_ofifo.sv]
// ----------------------------------------------------------------------------
// zsce_ofifo
// Result queue between the back end and the receiver.
// ----------------------------------------------------------------------------
module zsce_ofifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  zsce_pkg::t_result            i_word,
    output logic [zsce_pkg::OutCntW-1:0] o_count,
    output logic                         o_empty,
    input  logic                         i_pop,
    output zsce_pkg::t_result            o_word
);
    import zsce_pkg::*;

    t_result            r_mem [OutDepth];
    logic [OutPtrW-1:0] r_wr_ptr;
    logic [OutPtrW-1:0] r_rd_ptr;
    logic [OutCntW-1:0] r_count;
    logic               pop;

    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_word  = r_mem[r_rd_ptr];
    assign pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

[hw/rtl/zoomed_sprite_chunk_expander.sv]
// ----------------------------------------------------------------------------
// zoomed_sprite_chunk_expander
// Expands sprite attribute entries into zoomed 16x16 chunk draw words.
// ----------------------------------------------------------------------------
// input side is a queue: a word goes in when i_push is high and o_full low.
// i_func low writes i_map_word into the chunk map at i_map_address; i_func
// high expands a sprite from the three attribute words.
// output side is a queue: a result word is on the o_ ports while o_empty is
// low and leaves when i_pop is high. o_last marks the final chunk of a sprite.
// config: i_cfg_wr_en writes i_cfg_wdata into register i_cfg_addr at once.
// a map write is done by the back end while it is idle. a sprite takes a
// start step, 2x2 or 4x4 map reads, one per cycle through the single map
// read port while the result queue has room, and a finish step; the back
// end takes no new command before that finish step. a result passes the
// command queue, map read and held-chunk registers, and is held back one word, as
// the last flag is known only after the next kept chunk or the end of grid.
// a two-entry command queue sits in front of the back end.
// reset restores the register defaults and empties both queues; the map holds
// no reset value. when the receiver stalls, the walk pauses once the four-entry
// result queue fills, and o_full rises once the command queue fills.
// ----------------------------------------------------------------------------
module zoomed_sprite_chunk_expander #(
    parameter int MAP_ADDR_BITS = zsce_pkg::MapAddrBitsDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic                     i_func,
    input  logic [MAP_ADDR_BITS-1:0] i_map_address,
    input  logic [15:0]              i_map_word,
    input  logic [31:0]              i_attr_word_a,
    input  logic [31:0]              i_attr_word_c,
    input  logic [31:0]              i_attr_word_d,
    input  logic                     i_cfg_wr_en,
    input  logic [2:0]               i_cfg_addr,
    input  logic [15:0]              i_cfg_wdata,
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic [15:0]              o_tile_code,
    output logic [7:0]               o_palette,
    output logic                     o_mirror_x,
    output logic                     o_mirror_y,
    output logic signed [12:0]       o_pos_x,
    output logic signed [12:0]       o_pos_y,
    output logic [18:0]              o_scale_x,
    output logic [18:0]              o_scale_y,
    output logic [15:0]              o_prio_mask,
    output logic                     o_last
);
    import zsce_pkg::*;

    logic                     cmd_valid;
    t_cmd                     cmd;
    logic [MAP_ADDR_BITS-1:0] cmd_addr;
    logic                     cmd_pop;
    logic [OutCntW-1:0]       out_count;
    logic                     res_push;
    t_result                  res_in;
    t_result                  res_out;

    zsce_front #(
        .MAP_ADDR_BITS(MAP_ADDR_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_func       (i_func),
        .i_map_address(i_map_address),
        .i_map_word   (i_map_word),
        .i_attr_word_a(i_attr_word_a),
        .i_attr_word_c(i_attr_word_c),
        .i_attr_word_d(i_attr_word_d),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .o_cmd_addr   (cmd_addr),
        .i_cmd_pop    (cmd_pop)
    );

    zsce_back #(
        .MAP_ADDR_BITS(MAP_ADDR_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .i_cmd_addr (cmd_addr),
        .o_cmd_pop  (cmd_pop),
        .i_out_count(out_count),
        .o_push     (res_push),
        .o_word     (res_in)
    );

    zsce_ofifo u_ofifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_word (res_in),
        .o_count(out_count),
        .o_empty(o_empty),
        .i_pop  (i_pop),
        .o_word (res_out)
    );

    assign o_tile_code = res_out.tile_code;
    assign o_palette   = res_out.palette;
    assign o_mirror_x  = res_out.mirror_x;
    assign o_mirror_y  = res_out.mirror_y;
    assign o_pos_x     = res_out.pos_x;
    assign o_pos_y     = res_out.pos_y;
    assign o_scale_x   = res_out.scale_x;
    assign o_scale_y   = res_out.scale_y;
    assign o_prio_mask = res_out.prio_mask;
    assign o_last      = res_out.last;

endmodule

[test/zoomed_sprite_chunk_expander_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zoomed_sprite_chunk_expander_tb
// Checks the sprite chunk expander against a self-contained prediction of
// every chunk word. Map writes and sprite entries go in through the input
// queue, and each popped word is compared field by field with the oldest
// predicted chunk. The run has a directed part under the reset settings,
// then random phases with extreme and random register settings and varied
// sender and receiver idling.
// ----------------------------------------------------------------------------
module zoomed_sprite_chunk_expander_tb;
    import zsce_pkg::*;

    localparam int MapBits     = MapAddrBitsDef;
    localparam int MapDepth    = 1 << MapBits;
    localparam int ResetCycles = 10;
    localparam int HoldOff     = 64;
    localparam int StallLimit  = 5000;

    localparam logic [2:0] CfgSpareLo = 3'd6;
    localparam logic [2:0] CfgSpareHi = 3'd7;

    typedef struct {
        bit               func;
        bit [MapBits-1:0] addr;
        bit [15:0]        word;
        bit [31:0]        a;
        bit [31:0]        c;
        bit [31:0]        d;
    } t_item;

    class chunk_tracker;
        bit [15:0]          map_image [MapDepth];
        logic signed [10:0] x_off = XOffsetReset;
        logic signed [10:0] y_off = YOffsetReset;
        logic [15:0]        primask [4] = '{Primask0Reset, Primask1Reset,
                                            Primask2Reset, Primask3Reset};
        t_result            expected_chunks [$];
        int                 mismatch_count = 0;
        int                 chunks_seen = 0;

        function void set_register(logic [2:0] index, logic [15:0] data);
            case (index)
                CfgXOffset:  x_off = data[10:0];
                CfgYOffset:  y_off = data[10:0];
                CfgPrimask0: primask[0] = data;
                CfgPrimask1: primask[1] = data;
                CfgPrimask2: primask[2] = data;
                CfgPrimask3: primask[3] = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_chunks.size();
        endfunction

        function void absorb_word(t_item it);
            t_result  kept [$];
            t_result  r;
            int       x, y, zx, zy, dim, row, col, px, py, ox0, ox1, oy0, oy1, slot;
            bit [9:0] uy;
            if (!it.func) begin
                map_image[it.addr] = it.word;
                return;
            end
            if (it.a[14:0] == 15'd0) return;
            zx = int'(it.a[22:16]) + 1;
            zy = int'(it.d[16:10]) + 1;
            uy = 10'd0 - it.d[9:0];
            y = int'(uy) + int'(y_off);
            x = int'(it.c[9:0]);
            if (x > int'(WrapLimit)) x -= int'(WrapAmount);
            if (y > int'(WrapLimit)) y -= int'(WrapAmount);
            x -= int'(x_off);
            dim = it.d[18] ? 4 : 2;
            for (int n = 0; n < dim * dim; n++) begin
                row = n / dim;
                col = n % dim;
                px = it.a[23] ? dim - 1 - col : col;
                py = it.d[17] ? dim - 1 - row : row;
                slot = (int'(it.a[14:0]) * 4 + px + py * dim) % MapDepth;
                if (map_image[slot] == EmptyCode) continue;
                ox0 = (col * zx) / dim;
                ox1 = ((col + 1) * zx) / dim;
                oy0 = (row * zy) / dim;
                oy1 = ((row + 1) * zy) / dim;
                r.tile_code = map_image[slot];
                r.palette   = PalBase | {1'b0, it.c[17:11]} | {1'b0, it.c[19:18], 5'b0};
                r.mirror_x  = ~it.a[23];
                r.mirror_y  = it.d[17];
                r.pos_x     = 13'(x + ox0);
                r.pos_y     = 13'(y + oy0);
                r.scale_x   = 19'((ox1 - ox0) << 12);
                r.scale_y   = 19'((oy1 - oy0) << 12);
                r.prio_mask = primask[it.c[19:18]];
                r.last      = 1'b0;
                kept.push_back(r);
            end
            if (kept.size() > 0) kept[kept.size() - 1].last = 1'b1;
            foreach (kept[i]) expected_chunks.push_back(kept[i]);
        endfunction

        task report_mismatch(string text);
            if (mismatch_count < 100) $display("mismatch at chunk %0d: %s", chunks_seen, text);
            mismatch_count++;
        endtask

        task check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, want_v));
        endtask

        task check_chunk(t_result got);
            t_result want;
            chunks_seen++;
            if (expected_chunks.size() == 0) begin
                report_mismatch($sformatf("word with no chunk pending, tile code %0h",
                                          got.tile_code));
                return;
            end
            want = expected_chunks.pop_front();
            check_field("tile_code", got.tile_code, want.tile_code);
            check_field("palette", got.palette, want.palette);
            check_field("mirror_x", got.mirror_x, want.mirror_x);
            check_field("mirror_y", got.mirror_y, want.mirror_y);
            check_field("pos_x", got.pos_x, want.pos_x);
            check_field("pos_y", got.pos_y, want.pos_y);
            check_field("scale_x", got.scale_x, want.scale_x);
            check_field("scale_y", got.scale_y, want.scale_y);
            check_field("prio_mask", got.prio_mask, want.prio_mask);
            check_field("last", got.last, want.last);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push = 1'b0;
    logic               o_full;
    logic               i_func = 1'b0;
    logic [MapBits-1:0] i_map_address = '0;
    logic [15:0]        i_map_word = '0;
    logic [31:0]        i_attr_word_a = '0;
    logic [31:0]        i_attr_word_c = '0;
    logic [31:0]        i_attr_word_d = '0;
    logic               i_cfg_wr_en = 1'b0;
    logic [2:0]         i_cfg_addr = CfgXOffset;
    logic [15:0]        i_cfg_wdata = '0;
    logic               o_empty;
    logic               i_pop = 1'b0;
    logic [15:0]        o_tile_code;
    logic [7:0]         o_palette;
    logic               o_mirror_x;
    logic               o_mirror_y;
    logic signed [12:0] o_pos_x;
    logic signed [12:0] o_pos_y;
    logic [18:0]        o_scale_x;
    logic [18:0]        o_scale_y;
    logic [15:0]        o_prio_mask;
    logic               o_last;

    chunk_tracker tracker = new;
    bit           map_filled [MapDepth];
    int           items_sent = 0;
    int           sender_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           quiet_cycles = 0;

    zoomed_sprite_chunk_expander #(
        .MAP_ADDR_BITS(MapBits)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_func       (i_func),
        .i_map_address(i_map_address),
        .i_map_word   (i_map_word),
        .i_attr_word_a(i_attr_word_a),
        .i_attr_word_c(i_attr_word_c),
        .i_attr_word_d(i_attr_word_d),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_tile_code  (o_tile_code),
        .o_palette    (o_palette),
        .o_mirror_x   (o_mirror_x),
        .o_mirror_y   (o_mirror_y),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_scale_x    (o_scale_x),
        .o_scale_y    (o_scale_y),
        .o_prio_mask  (o_prio_mask),
        .o_last       (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_item   seen;
        t_result got;
        if (i_rst_n) begin
            if (i_cfg_wr_en) tracker.set_register(i_cfg_addr, i_cfg_wdata);
            if (i_push && !o_full) begin
                seen = '{func: i_func, addr: i_map_address, word: i_map_word,
                         a: i_attr_word_a, c: i_attr_word_c, d: i_attr_word_d};
                tracker.absorb_word(seen);
            end
            if (i_pop && !o_empty) begin
                got = '{tile_code: o_tile_code, palette: o_palette, mirror_x: o_mirror_x,
                        mirror_y: o_mirror_y, pos_x: o_pos_x, pos_y: o_pos_y,
                        scale_x: o_scale_x, scale_y: o_scale_y, prio_mask: o_prio_mask,
                        last: o_last};
                tracker.check_chunk(got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == StallLimit) begin
            $display("zoomed_sprite_chunk_expander test failed");
            $finish;
        end
    end

    function automatic bit [15:0] random_code();
        return ($urandom_range(4) == 0) ? EmptyCode : 16'($urandom);
    endfunction

    function automatic t_item write_item(bit [MapBits-1:0] addr, bit [15:0] word);
        return '{func: 1'b0, addr: addr, word: word, a: $urandom, c: $urandom, d: $urandom};
    endfunction

    function automatic t_item sprite_item(bit [31:0] a, bit [31:0] c, bit [31:0] d);
        return '{func: 1'b1, addr: MapBits'($urandom), word: 16'($urandom), a: a, c: c, d: d};
    endfunction

    // junk sets the attribute bits the block ignores
    function automatic t_item sprite_fields(bit fx, bit [6:0] zx, bit [14:0] tile,
                                            bit [1:0] prio, bit [7:0] bank, bit [9:0] x,
                                            bit dbl, bit fy, bit [6:0] zy, bit [9:0] y,
                                            bit junk);
        return sprite_item({{8{junk}}, fx, zx, junk, tile},
                           {{12{junk}}, prio, bank, x},
                           {{13{junk}}, dbl, fy, zy, y});
    endfunction

    task automatic send_item(t_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push        <= 1'b1;
        i_func        <= it.func;
        i_map_address <= it.addr;
        i_map_word    <= it.word;
        i_attr_word_a <= it.a;
        i_attr_word_c <= it.c;
        i_attr_word_d <= it.d;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        if (!it.func) map_filled[it.addr] = 1'b1;
        items_sent++;
    endtask

    // every map entry a sprite reads must have been written first
    task automatic ensure_tile(int tile, int dim);
        int slot;
        for (int k = 0; k < dim * dim; k++) begin
            slot = (tile * 4 + k) % MapDepth;
            if (!map_filled[slot] || $urandom_range(7) == 0)
                send_item(write_item(MapBits'(slot), random_code()));
        end
    endtask

    task automatic run_random(int count);
        int        target, pick, tile;
        bit [31:0] a, c, d;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                send_item(write_item(MapBits'($urandom), random_code()));
            end else begin
                a = $urandom;
                c = $urandom;
                d = $urandom;
                if (pick < 22) tile = 0;
                else if (pick < 70) tile = $urandom_range(40, 1);
                else if (pick < 82) tile = $urandom_range(32767, 32760);
                else tile = $urandom_range(32767, 1);
                a[14:0] = 15'(tile);
                if (tile != 0) ensure_tile(tile, d[18] ? 4 : 2);
                send_item(sprite_item(a, c, d));
            end
        end
    endtask

    task automatic drain_results(bit hold);
        i_push <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        if (hold) repeat (HoldOff) @(posedge i_clk);
    endtask

    task automatic write_config(logic [15:0] xo, logic [15:0] yo, logic [15:0] m0,
                                logic [15:0] m1, logic [15:0] m2, logic [15:0] m3);
        logic [2:0]  reg_index [8];
        logic [15:0] reg_value [8];
        reg_index = '{CfgXOffset, CfgYOffset, CfgPrimask0, CfgPrimask1,
                      CfgPrimask2, CfgPrimask3, CfgSpareLo, CfgSpareHi};
        reg_value = '{xo, yo, m0, m1, m2, m3, 16'($urandom), 16'($urandom)};
        for (int i = 0; i < 8; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_addr  <= reg_index[i];
            i_cfg_wdata <= reg_value[i];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [15:0] code;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tile 1 grid, with a fully empty 2x2 block that tile 2 reads alone
        for (int k = 0; k < 16; k++) begin
            if (k >= 4 && k < 8) code = EmptyCode;
            else if (k == 0) code = 16'h0000;
            else if (k == 15) code = 16'hfffe;
            else code = {4'(k), 12'($urandom)};
            send_item(write_item(MapBits'(4 + k), code));
        end
        for (int k = 0; k < 4; k++)
            send_item(write_item(MapBits'(MapDepth - 4 + k), random_code()));
        send_item(sprite_fields(1'b0, 7'h00, 15'd1, 2'd0, 8'h00, 10'h000,
                                1'b0, 1'b0, 7'h00, 10'h000, 1'b0));
        send_item(sprite_fields(1'b1, 7'h7f, 15'd1, 2'd3, 8'hff, 10'h3ff,
                                1'b1, 1'b1, 7'h7f, 10'h3ff, 1'b1));
        send_item(sprite_fields(1'b1, 7'h40, 15'd1, 2'd1, 8'h55, 10'h341,
                                1'b1, 1'b0, 7'h15, 10'h340, 1'b0));
        send_item(sprite_fields(1'b0, 7'h7f, 15'd1, 2'd2, 8'haa, 10'h340,
                                1'b0, 1'b1, 7'h00, 10'h001, 1'b0));
        send_item(sprite_item(32'hffff8000, 32'hffffffff, 32'hffffffff));
        send_item(sprite_fields(1'b0, 7'h10, 15'd2, 2'd1, 8'h12, 10'h100,
                                1'b0, 1'b0, 7'h10, 10'h100, 1'b0));
        send_item(sprite_fields(1'b1, 7'h03, 15'h7fff, 2'd0, 8'h81, 10'h200,
                                1'b0, 1'b1, 7'h22, 10'h050, 1'b1));
        drain_results(1'b1);

        write_config({5'h1f, 11'h400}, {5'h00, 11'h3ff},
                     16'h0000, 16'hffff, 16'h5555, 16'haaaa);
        sender_idle_pct = 47;
        recv_stall_pct  = 0;
        run_random(50);
        drain_results(1'b0);
        run_random(50);
        drain_results(1'b1);

        write_config({5'h00, 11'h3ff}, {5'h1f, 11'h400},
                     16'hffff, 16'h0000, 16'haaaa, 16'h5555);
        sender_idle_pct = 0;
        recv_stall_pct  = 47;
        run_random(100);
        drain_results(1'b1);

        write_config(16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
        sender_idle_pct = 13;
        recv_stall_pct  = 13;
        run_random(100);
        drain_results(1'b1);

        write_config({5'h0a, 11'h000}, {5'h15, 11'h000}, 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        run_random(100);
        drain_results(1'b1);

        if (tracker.mismatch_count == 0) $display("zoomed_sprite_chunk_expander test passed");
        else $display("zoomed_sprite_chunk_expander test failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/zsce_pkg.sv
hw/rtl/zsce_front.sv
hw/rtl/zsce_back.sv
hw/rtl/zsce_ofifo.sv
hw/rtl/zoomed_sprite_chunk_expander.sv
test/zoomed_sprite_chunk_expander_tb.sv
